[design/font_5x7_text_renderer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 5x7 font text renderer
// Concurrent checks clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FONT_5X7_TEXT_RENDERER_ASSERT_SVH
`define FONT_5X7_TEXT_RENDERER_ASSERT_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define F57TR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle.
`define F57TR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define F57TR_ASSERT_NOW(lbl, ante, cons, msg)
`define F57TR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/f57tr_pkg.sv]
// ----------------------------------------------------------------------------
// f57tr_pkg
// Types, constants and the 5x7 glyph ROM shared by the text renderer.
// ----------------------------------------------------------------------------
package f57tr_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int GLYPH_COUNT = 91;
  localparam int ROM_SIZE    = 91;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd122;
  localparam int CELL_W      = 6;
  localparam int CELL_H      = 7;
  localparam int GLYPH_COLS  = 5;

  localparam int DIM_W   = 11;   // configuration register width
  localparam int COORD_W = 12;   // cell coordinates reach 1023 + 6*255 + 6
  localparam int ADDR_W  = 20;
  localparam int COLOR_W = 16;
  localparam int PROD_W  = COORD_W + DIM_W;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCREEN_WIDTH   = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_LANDSCAPE_MODE = 2'd2;

  typedef struct packed {
    logic [7:0]         char_code;
    logic [9:0]         origin_x;
    logic [9:0]         origin_y;
    logic [7:0]         char_index;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bkgnd_color;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_addr;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_req_t;

  // Row r of a glyph is element r; bit 4 of a row is the leftmost column.
  typedef logic [0:CELL_H-1][GLYPH_COLS-1:0] glyph_t;

  // One character ready to be drawn: the glyph, the address of its first
  // visible pixel and the last visible inner and outer step.
  typedef struct packed {
    glyph_t             glyph;
    logic               landscape;
    logic [2:0]         last_inner;
    logic [2:0]         last_outer;
    logic [ADDR_W-1:0]  base_addr;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bkgnd_color;
  } job_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bk_status_t;

  localparam glyph_t BOX_GLYPH = {5'h1F,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1F};

  localparam glyph_t GLYPH_ROM [ROM_SIZE] = '{
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h04,5'h04,5'h04,5'h04,5'h00,5'h04,5'h00},
    {5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h00,5'h00},
    {5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04}, {5'h18,5'h19,5'h02,5'h04,5'h08,5'h13,5'h03},
    {5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D}, {5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
    {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02}, {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08},
    {5'h00,5'h0A,5'h04,5'h1F,5'h04,5'h0A,5'h00}, {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00},
    {5'h00,5'h00,5'h00,5'h00,5'h04,5'h04,5'h08}, {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00},
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h00}, {5'h00,5'h01,5'h02,5'h04,5'h08,5'h10,5'h00},
    {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}, {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}, {5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E},
    {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
    {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E}, {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
    {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
    {5'h00,5'h04,5'h00,5'h00,5'h04,5'h00,5'h00}, {5'h00,5'h04,5'h00,5'h00,5'h04,5'h04,5'h08},
    {5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02}, {5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00},
    {5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08}, {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
    {5'h0E,5'h11,5'h01,5'h0D,5'h15,5'h15,5'h0E}, {5'h0E,5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11},
    {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E}, {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
    {5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C}, {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
    {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10}, {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F},
    {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C}, {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
    {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F}, {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
    {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11}, {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10}, {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
    {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11}, {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
    {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04}, {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04}, {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11},
    {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11}, {5'h11,5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04},
    {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F}, {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h00,5'h10,5'h08,5'h04,5'h02,5'h01,5'h00}, {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E},
    {5'h04,5'h0A,5'h11,5'h00,5'h00,5'h00,5'h00}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F},
    {5'h08,5'h04,5'h02,5'h00,5'h00,5'h00,5'h00}, {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F},
    {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h1E}, {5'h00,5'h00,5'h0E,5'h10,5'h10,5'h11,5'h0E},
    {5'h01,5'h01,5'h0D,5'h13,5'h11,5'h11,5'h0F}, {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E},
    {5'h06,5'h09,5'h08,5'h1C,5'h08,5'h08,5'h08}, {5'h00,5'h00,5'h0F,5'h11,5'h11,5'h0F,5'h01},
    {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11}, {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E},
    {5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C}, {5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12},
    {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E}, {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h11,5'h11},
    {5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11}, {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E},
    {5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10}, {5'h00,5'h00,5'h0D,5'h13,5'h0F,5'h01,5'h01},
    {5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10}, {5'h00,5'h00,5'h0E,5'h10,5'h0E,5'h01,5'h1E},
    {5'h08,5'h08,5'h1C,5'h08,5'h08,5'h09,5'h06}, {5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D},
    {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04}, {5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A},
    {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11}, {5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E},
    {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F}
  };

  // Glyph for a character code; codes outside the font give a hollow box.
  function automatic glyph_t glyph_lookup(logic [7:0] code);
    logic [7:0] gi;
    gi = code - FIRST_CODE;
    if (code >= FIRST_CODE && code <= LAST_CODE && 32'(gi) < GLYPH_COUNT
        && 32'(gi) < ROM_SIZE) begin
      return GLYPH_ROM[gi[6:0]];
    end
    return BOX_GLYPH;
  endfunction

  // Clamp a screen dimension register to the supported maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
    if (32'(d) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

[design/font_5x7_text_renderer.sv]
// ----------------------------------------------------------------------------
// font_5x7_text_renderer
// Draws one 6x7 character cell from a 5x7 font as framebuffer pixel writes.
// Each input request carries a character, the string origin, the position in
// the string and two RGB565 colors. Each output request is one pixel write:
// address (row times screen width plus column), color, and a flag on the
// last pixel of the character. Off-screen pixels are skipped, and a fully
// clipped character produces no output at all.
// The front end registers a request, clips it and fetches the glyph; the
// back end walks the visible pixels one per cycle, while the receiver does
// not stall, through an output register. A job queue between them lets the
// front keep taking requests while the back is drawing; the walker sets the
// sustained rate. A request passes the front register, a queue entry and the
// back-end job register before its first pixel is presented. A character has
// at most 42 visible pixels. Reset restores a 320x240 horizontal screen and
// empties the pipeline. When the receiver stalls, the output holds and the
// stall backs up through the queue to in_stall. Configuration is to be
// written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "font_5x7_text_renderer_assert.svh"

module font_5x7_text_renderer #(
  parameter int QUEUE_DEPTH = f57tr_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  f57tr_pkg::in_req_t          in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output f57tr_pkg::out_req_t         out_req,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [f57tr_pkg::DIM_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [f57tr_pkg::DIM_W-1:0] screen_width_r, screen_height_r;
  logic                        landscape_mode_r;

  // Front to queue and queue to back.
  logic                  q_push, q_full, q_empty;
  f57tr_pkg::job_t       q_job, q_head;
  f57tr_pkg::bk_status_t bk_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r   <= f57tr_pkg::DIM_W'(320);
      screen_height_r  <= f57tr_pkg::DIM_W'(240);
      landscape_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        f57tr_pkg::REG_SCREEN_WIDTH:   screen_width_r   <= cfg_wdata;
        f57tr_pkg::REG_SCREEN_HEIGHT:  screen_height_r  <= cfg_wdata;
        f57tr_pkg::REG_LANDSCAPE_MODE: landscape_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Front end: takes a character, clips its cell and builds a drawing job
  // with the address of its first visible pixel.
  f57tr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req         (in_req),
    .screen_width   (screen_width_r),
    .screen_height  (screen_height_r),
    .landscape_mode (landscape_mode_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_job)
  );

  f57tr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (bk_stat.pop),
    .head_job (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: steps across each visible row, adding the screen width to the
  // row address at every new row, and emits one pixel per cycle unless stalled.
  f57tr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .screen_width (screen_width_r),
    .status       (bk_stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_req      (out_req)
  );

  // The queue cannot look full and empty at once.
  `F57TR_ASSERT_NOW(a_queue_state, 1'b1, !(q_full && q_empty), "queue full and empty")
  // The back end only takes a job that is there.
  `F57TR_ASSERT_NOW(a_pop_nonempty, bk_stat.pop, !q_empty, "pop from empty queue")
  // A pixel that is not the last one means its character is still being drawn.
  `F57TR_ASSERT_NOW(a_mid_char_busy, out_valid && !out_req.last_pixel, bk_stat.busy,
                    "non-last pixel without an active character")
  // Finishing a character with nothing queued leaves the back end idle.
  `F57TR_ASSERT_NEXT(a_idle_after_last,
                     out_valid && !out_stall && out_req.last_pixel && !bk_stat.busy
                     && q_empty, !out_valid, "pixel emitted after last with no job")

endmodule

[design/f57tr_front.sv]
// ----------------------------------------------------------------------------
// f57tr_front
// Accepts characters, clips the cell, looks up the glyph and forms a job.
// ----------------------------------------------------------------------------
module f57tr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  f57tr_pkg::in_req_t            in_req,
  input  logic [f57tr_pkg::DIM_W-1:0]   screen_width,
  input  logic [f57tr_pkg::DIM_W-1:0]   screen_height,
  input  logic                          landscape_mode,
  input  logic                          q_full,
  output logic                          q_push,
  output f57tr_pkg::job_t               q_job
);

  localparam int CW = f57tr_pkg::COORD_W;

  logic                          s1_valid_r;
  f57tr_pkg::glyph_t             glyph_r;
  logic                          landscape_r;
  logic [2:0]                    last_inner_r, last_outer_r;
  logic [CW-1:0]                 cx_r, cy_r;
  logic [f57tr_pkg::COLOR_W-1:0] fg_r, bg_r;

  logic [f57tr_pkg::DIM_W-1:0] w, h;
  logic [CW-1:0]               step, cx, cy, rem_x, rem_y;
  logic [2:0]                  lim_x, lim_y, last_inner, last_outer;
  logic                        visible, load;
  logic [f57tr_pkg::PROD_W-1:0] prod;

  always_comb begin
    w     = f57tr_pkg::clamp_dim(screen_width);
    h     = f57tr_pkg::clamp_dim(screen_height);
    step  = CW'(in_req.char_index) * CW'(f57tr_pkg::CELL_W);
    cx    = CW'(in_req.origin_x) + (landscape_mode ? '0 : step);
    cy    = CW'(in_req.origin_y) + (landscape_mode ? step : '0);
    rem_x = CW'(w) - cx;
    rem_y = CW'(h) - cy;
    // Inner steps run along x, outer steps along y in both orientations.
    lim_x = landscape_mode ? 3'(f57tr_pkg::CELL_H - 1) : 3'(f57tr_pkg::CELL_W - 1);
    lim_y = landscape_mode ? 3'(f57tr_pkg::CELL_W - 1) : 3'(f57tr_pkg::CELL_H - 1);
    // The origin check is covered since the cell corner is never left of it.
    visible    = (cx < CW'(w)) && (cy < CW'(h));
    last_inner = (rem_x > CW'(lim_x)) ? lim_x : 3'(rem_x - CW'(1));
    last_outer = (rem_y > CW'(lim_y)) ? lim_y : 3'(rem_y - CW'(1));
  end

  assign q_push   = s1_valid_r && !q_full;
  assign in_stall = s1_valid_r && q_full;
  assign load     = !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= in_valid && visible;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyph_r      <= f57tr_pkg::glyph_lookup(in_req.char_code);
      landscape_r  <= landscape_mode;
      last_inner_r <= last_inner;
      last_outer_r <= last_outer;
      cx_r         <= cx;
      cy_r         <= cy;
      fg_r         <= in_req.fg_color;
      bg_r         <= in_req.bkgnd_color;
    end
  end

  // The address stride is the raw register, not the clamped width.
  always_comb begin
    prod = f57tr_pkg::PROD_W'(cy_r) * f57tr_pkg::PROD_W'(screen_width);
    q_job.glyph       = glyph_r;
    q_job.landscape   = landscape_r;
    q_job.last_inner  = last_inner_r;
    q_job.last_outer  = last_outer_r;
    q_job.base_addr   = f57tr_pkg::ADDR_W'(prod + f57tr_pkg::PROD_W'(cx_r));
    q_job.fg_color    = fg_r;
    q_job.bkgnd_color = bg_r;
  end

endmodule

[design/f57tr_queue.sv]
// ----------------------------------------------------------------------------
// f57tr_queue
// Small job queue between the front and the back end.
// ----------------------------------------------------------------------------
module f57tr_queue #(
  parameter int DEPTH = f57tr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  f57tr_pkg::job_t push_job,
  input  logic            pop,
  output f57tr_pkg::job_t head_job,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  f57tr_pkg::job_t  entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[design/f57tr_back.sv]
// ----------------------------------------------------------------------------
// f57tr_back
// Walks the visible part of a cell, one pixel write per cycle unless stalled.
// ----------------------------------------------------------------------------
module f57tr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  f57tr_pkg::job_t             q_head,
  input  logic [f57tr_pkg::DIM_W-1:0] screen_width,
  output f57tr_pkg::bk_status_t       status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output f57tr_pkg::out_req_t         out_req
);

  logic                             busy_r;
  f57tr_pkg::job_t                  job_r;
  logic [2:0]                       inner_r, outer_r;
  logic [f57tr_pkg::ADDR_W-1:0]     row_addr_r;
  logic                             out_valid_r;
  f57tr_pkg::out_req_t              out_req_r;

  logic       adv, emit, row_end, is_last, pop, pix_on;
  logic [2:0] col_bit;

  always_comb begin
    adv     = !out_valid_r || !out_stall;
    emit    = busy_r && adv;
    row_end = (inner_r == job_r.last_inner);
    is_last = row_end && (outer_r == job_r.last_outer);
    pop     = !q_empty && (!busy_r || (emit && is_last));
    // Landscape turns the cell: glyph row follows x, glyph column follows y.
    if (job_r.landscape) begin
      col_bit = outer_r;
      pix_on  = (outer_r < 3'(f57tr_pkg::GLYPH_COLS)) && job_r.glyph[inner_r][col_bit];
    end else begin
      col_bit = 3'(f57tr_pkg::GLYPH_COLS - 1) - inner_r;
      pix_on  = (inner_r < 3'(f57tr_pkg::GLYPH_COLS)) && job_r.glyph[outer_r][col_bit];
    end
  end

  assign status.busy = busy_r;
  assign status.pop  = pop;
  assign out_valid   = out_valid_r;
  assign out_req     = out_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r      <= q_head;
      inner_r    <= '0;
      outer_r    <= '0;
      row_addr_r <= q_head.base_addr;
    end else if (emit && !is_last) begin
      if (row_end) begin
        inner_r    <= '0;
        outer_r    <= outer_r + 3'd1;
        row_addr_r <= row_addr_r + f57tr_pkg::ADDR_W'(screen_width);
      end else begin
        inner_r <= inner_r + 3'd1;
      end
    end
    if (emit) begin
      out_req_r.pixel_addr  <= row_addr_r + f57tr_pkg::ADDR_W'(inner_r);
      out_req_r.pixel_color <= pix_on ? job_r.fg_color : job_r.bkgnd_color;
      out_req_r.last_pixel  <= is_last;
    end
  end

endmodule
